// File: rtl/core/cpcsd_pkg.sv
// Package with the beat types, register codes and state encodings of the cycle slip detector.
`default_nettype none
package cpcsd_pkg;

  localparam logic [31:0] MAX_GAP_RESET     = 32'd1024;
  localparam logic [15:0] SIGMA_LIMIT_RESET = 16'd1024;
  localparam logic [23:0] START_SIGMA_RESET = 24'd1024;
  localparam logic [6:0]  WINDOW_RESET      = 7'd60;
  localparam logic [6:0]  DEFAULT_WINDOW    = 7'd60;

  localparam logic [2:0] EPOCH_FLAG_PWR_FAIL   = 3'd1;
  localparam logic [2:0] EPOCH_FLAG_CYCLE_SLIP = 3'd6;

  localparam int unsigned HEAD_W  = 10;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [1:0] {
    CFG_MAX_GAP      = 2'd0,
    CFG_SIGMA_LIMIT  = 2'd1,
    CFG_START_SIGMA  = 2'd2,
    CFG_WINDOW_LIMIT = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_CHK, ST_SQ, ST_THR1, ST_THR2,
    ST_DIV, ST_APPLY, ST_RST, ST_WR, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_MEAN, PH_VAR, PH_OMEAN, PH_OVAR
  } phase_e;

  typedef struct packed {
    logic [5:0]         sat_index;
    logic [47:0]        epoch_time;
    logic [2:0]         epoch_flag;
    logic [2:0]         lli_flags;
    logic               obs_present;
    logic signed [39:0] code_range;
    logic signed [39:0] carrier_phase;
    logic               prior_slip;
  } in_beat_t;

  typedef struct packed {
    logic [5:0] out_sat;
    logic       slip;
    logic       drop;
  } out_beat_t;

  typedef struct packed {
    logic [47:0]        last_epoch;
    logic [COUNT_W-1:0] count;
    logic signed [47:0] mean;
    logic [63:0]        variance;
    logic [HEAD_W-1:0]  head;
  } slot_rec_t;

  typedef struct packed {
    logic signed [47:0] bias;
    logic [63:0]        dev;
  } ring_rec_t;

endpackage
`default_nettype wire

// File: rtl/core/cpcsd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module cpcsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/code_phase_cycle_slip_detector_unit.sv
// Top level of the code-minus-phase cycle slip detector with per-slot state in RAM.
// A missing observation or an out-of-range slot goes straight to the output register; a restart
// passes the read, check, square, threshold, restart and write states. A window update uses the
// one shared divider twice and a full window four times; it retires 2 quotient bits a cycle.
// Throughput: one item at a time; the next beat is taken once the result sits in the output register.
// Reset clears the configuration, the slot valid bits and the handshake state; the RAMs are not cleared.
`default_nettype none
module code_phase_cycle_slip_detector_unit #(
  parameter int unsigned SATELLITES   = 64,
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire cpcsd_pkg::in_beat_t  in_beat_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output cpcsd_pkg::out_beat_t      out_beat_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);
  import cpcsd_pkg::*;

  localparam int unsigned SW = (SATELLITES > 1) ? $clog2(SATELLITES) : 1;
  localparam int unsigned HW = $clog2(WINDOW_DEPTH);
  localparam int unsigned RW = SW + HW;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [31:0] max_gap_q;
  logic [15:0] sigma_limit_q;
  logic [23:0] start_sigma_q;
  logic [6:0]  window_q;
  logic [31:0] sl2_q;

  in_beat_t           item_q;
  logic signed [40:0] bias_q;
  logic               restart_q, dneg_q, up_q, remove_q;
  logic [49:0]        mag_q;
  logic [63:0]        d2_q, hp_q;
  logic [47:0]        lp_q;
  logic [COUNT_W-1:0] n_q;
  logic [COUNT_W-1:0] newc_q;
  logic signed [47:0] mean_q;
  logic [63:0]        var_q;
  logic [63:0]        div_quo_q;
  logic [COUNT_W-1:0] div_rem_q, div_den_q;
  logic [5:0]         div_cnt_q;
  logic               slip_q, drop_q;
  logic               out_valid_q;
  out_beat_t          out_q;
  logic [SATELLITES-1:0] valid_q;

  logic             in_accept, out_load, out_free;
  logic [SW-1:0]    sat_a;
  logic             in_range;
  slot_rec_t        rec, rec_wr;
  logic [$bits(slot_rec_t)-1:0] slot_rdata;
  logic             slot_re, slot_we;
  ring_rec_t        ring_rd, ring_wr;
  logic [$bits(ring_rec_t)-1:0] ring_rdata;
  logic             ring_re, ring_we;
  logic [RW-1:0]    ring_raddr, ring_waddr;
  logic             cur_valid;
  logic [HW-1:0]    h_cur, h_next, oi, r_off;
  logic [HW+1:0]    oi_sum;
  logic [COUNT_W-1:0] n_c, lim;
  logic [6:0]       lim_raw;
  logic signed [49:0] d_c;
  logic             gap_hit, early_restart;
  logic [63:0]      sq_p, hp_p, lp_p;
  logic [47:0]      ss2_p;
  logic [63:0]      hs;
  logic [64:0]      thr_sum;
  logic [63:0]      thr;
  logic             thr_hit;
  logic [63:0]      quo_n;
  logic [COUNT_W-1:0] rem_n;
  logic signed [50:0] q_s, msum;
  logic signed [47:0] m_clamp;
  logic [64:0]      vsum;
  logic [63:0]      vdiff;
  logic signed [48:0] e_c;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_OUT) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign sat_a    = SW'(item_q.sat_index);
  assign in_range = (32'(in_beat_i.sat_index) < SATELLITES);

  assign lim_raw = (window_q == 7'd0) ? DEFAULT_WINDOW : window_q;
  assign lim     = (32'(lim_raw) > WINDOW_DEPTH) ? COUNT_W'(WINDOW_DEPTH) : COUNT_W'(lim_raw);

  assign rec       = slot_rec_t'(slot_rdata);
  assign ring_rd   = ring_rec_t'(ring_rdata);
  assign cur_valid = valid_q[sat_a];
  assign h_cur     = cur_valid ? rec.head[HW-1:0] : '0;
  assign h_next    = (32'(h_cur) == WINDOW_DEPTH - 1) ? '0 : h_cur + 1'b1;
  assign n_c       = rec.count + 1'b1;

  assign r_off  = (32'(rec.count) >= WINDOW_DEPTH) ? '0 : HW'(rec.count);
  assign oi_sum = (HW+2)'(h_cur) + (HW+2)'(WINDOW_DEPTH) - (HW+2)'(r_off);
  assign oi     = (32'(oi_sum) >= WINDOW_DEPTH) ? HW'(oi_sum - (HW+2)'(WINDOW_DEPTH))
                                                : HW'(oi_sum);

  assign d_c = {{9{bias_q[40]}}, bias_q} - {{2{rec.mean[47]}}, rec.mean};
  assign gap_hit = (item_q.epoch_time > rec.last_epoch) &&
                   ((item_q.epoch_time - rec.last_epoch) > {16'b0, max_gap_q});
  assign early_restart = !cur_valid || (item_q.epoch_flag == EPOCH_FLAG_PWR_FAIL) ||
                         (item_q.epoch_flag == EPOCH_FLAG_CYCLE_SLIP) ||
                         item_q.lli_flags[0] || gap_hit;

  assign sq_p  = {32'b0, mag_q[31:0]} * {32'b0, mag_q[31:0]};
  assign hp_p  = {32'b0, var_q[63:32]} * {32'b0, sl2_q};
  assign lp_p  = {32'b0, var_q[31:0]} * {32'b0, sl2_q};
  assign ss2_p = {24'b0, start_sigma_q} * {24'b0, start_sigma_q};
  assign hs      = {hp_q[47:0], 16'b0};
  assign thr_sum = {1'b0, hs} + {17'b0, lp_q};
  assign thr     = ((hp_q[63:48] != 16'd0) || thr_sum[64]) ? '1 : thr_sum[63:0];
  assign thr_hit = (d2_q >= thr);

  always_comb begin
    logic [COUNT_W:0] t9;
    quo_n = div_quo_q;
    rem_n = div_rem_q;
    for (int k = 0; k < 2; k++) begin
      t9    = {rem_n, quo_n[63]};
      quo_n = {quo_n[62:0], 1'b0};
      if (t9 >= {1'b0, div_den_q}) begin
        rem_n    = COUNT_W'(t9 - {1'b0, div_den_q});
        quo_n[0] = 1'b1;
      end else begin
        rem_n = t9[COUNT_W-1:0];
      end
    end
  end

  assign q_s  = dneg_q ? -$signed({1'b0, div_quo_q[49:0]}) : $signed({1'b0, div_quo_q[49:0]});
  assign msum = {{3{mean_q[47]}}, mean_q} + q_s;
  assign m_clamp = (msum > 51'sh7FFFFFFFFFFF) ? 48'sh7FFFFFFFFFFF :
                   (msum < -51'sh800000000000) ? -48'sh800000000000 : msum[47:0];
  assign vsum  = {1'b0, var_q} + {1'b0, div_quo_q};
  assign vdiff = var_q - div_quo_q;
  assign e_c   = {mean_q[47], mean_q} - {ring_rd.bias[47], ring_rd.bias};

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    slot_re = 1'b0;
    ring_re = 1'b0;
    slot_we = 1'b0;
    ring_we = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (in_beat_i.obs_present && in_range) ? ST_RD : ST_OUT;
        end
      end
      ST_RD: begin
        slot_re = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK:  state_d = ST_SQ;
      ST_SQ:   state_d = ST_THR1;
      ST_THR1: state_d = ST_THR2;
      ST_THR2: begin
        if (restart_q || thr_hit) begin
          state_d = ST_RST;
        end else begin
          ring_re = (n_q > lim);
          phase_d = PH_MEAN;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == 6'd1) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d = ST_DIV;
        unique case (phase_q)
          PH_MEAN:  phase_d = PH_VAR;
          PH_VAR: begin
            if (remove_q) begin
              phase_d = PH_OMEAN;
            end else begin
              state_d = ST_WR;
            end
          end
          PH_OMEAN: phase_d = PH_OVAR;
          PH_OVAR:  state_d = ST_WR;
          default:  state_d = ST_WR;
        endcase
      end
      ST_RST: state_d = ST_WR;
      ST_WR: begin
        slot_we = 1'b1;
        ring_we = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_MEAN;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q     <= MAX_GAP_RESET;
      sigma_limit_q <= SIGMA_LIMIT_RESET;
      start_sigma_q <= START_SIGMA_RESET;
      window_q      <= WINDOW_RESET;
      sl2_q         <= '0;
      out_valid_q   <= 1'b0;
      valid_q       <= '0;
      div_cnt_q     <= '0;
    end else begin
      sl2_q <= {16'b0, sigma_limit_q} * {16'b0, sigma_limit_q};
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_MAX_GAP:      max_gap_q     <= cfg_data_i;
          CFG_SIGMA_LIMIT:  sigma_limit_q <= cfg_data_i[15:0];
          CFG_START_SIGMA:  start_sigma_q <= cfg_data_i[23:0];
          CFG_WINDOW_LIMIT: window_q      <= cfg_data_i[6:0];
          default:          max_gap_q     <= max_gap_q;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (slot_we) begin
        valid_q[sat_a] <= 1'b1;
      end
      if (state_q == ST_THR2 && !(restart_q || thr_hit)) begin
        div_cnt_q <= 6'd32;
      end else if (state_q == ST_APPLY && state_d == ST_DIV) begin
        div_cnt_q <= 6'd32;
      end else if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.out_sat <= item_q.sat_index;
      out_q.slip    <= slip_q;
      out_q.drop    <= drop_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          item_q <= in_beat_i;
          drop_q <= !in_beat_i.obs_present;
          slip_q <= in_beat_i.obs_present && in_beat_i.prior_slip;
        end
      end
      ST_RD: begin
        bias_q <= {item_q.code_range[39], item_q.code_range} -
                  {item_q.carrier_phase[39], item_q.carrier_phase};
      end
      ST_CHK: begin
        restart_q <= early_restart;
        dneg_q    <= d_c[49];
        mag_q     <= d_c[49] ? 50'(-d_c) : 50'(d_c);
        n_q       <= n_c;
        mean_q    <= rec.mean;
        var_q     <= rec.variance;
      end
      ST_SQ: begin
        d2_q <= (mag_q > 50'h0_FFFF_FFFF) ? '1 : sq_p;
        hp_q <= hp_p;
      end
      ST_THR1: lp_q <= lp_p[63:16];
      ST_THR2: begin
        restart_q <= restart_q || thr_hit;
        remove_q  <= (n_q > lim);
        newc_q    <= (n_q > lim) ? lim : n_q;
        div_quo_q <= {14'b0, mag_q};
        div_rem_q <= '0;
        div_den_q <= n_q;
      end
      ST_DIV: begin
        div_quo_q <= quo_n;
        div_rem_q <= rem_n;
      end
      ST_APPLY: begin
        div_rem_q <= '0;
        case (phase_q)
          PH_MEAN: begin
            mean_q    <= m_clamp;
            up_q      <= (d2_q >= var_q);
            div_quo_q <= (d2_q >= var_q) ? d2_q - var_q : var_q - d2_q;
            div_den_q <= n_q;
          end
          PH_VAR: begin
            var_q     <= up_q ? vsum[63:0] : vdiff;
            dneg_q    <= e_c[48];
            div_quo_q <= e_c[48] ? 64'(-e_c) : 64'(e_c);
            div_den_q <= lim;
          end
          PH_OMEAN: begin
            mean_q    <= m_clamp;
            up_q      <= (var_q >= ring_rd.dev);
            div_quo_q <= (var_q >= ring_rd.dev) ? var_q - ring_rd.dev : ring_rd.dev - var_q;
            div_den_q <= lim;
          end
          default: begin
            if (up_q) begin
              var_q <= vsum[64] ? '1 : vsum[63:0];
            end else begin
              var_q <= (div_quo_q > var_q) ? '0 : vdiff;
            end
          end
        endcase
      end
      ST_RST: begin
        mean_q <= {{7{bias_q[40]}}, bias_q};
        var_q  <= {16'b0, ss2_p};
        d2_q   <= '0;
        newc_q <= COUNT_W'(1);
      end
      ST_WR: slip_q <= restart_q || item_q.prior_slip;
      default: ;
    endcase
  end

  always_comb begin
    rec_wr.last_epoch = item_q.epoch_time;
    rec_wr.count      = newc_q;
    rec_wr.mean       = mean_q;
    rec_wr.variance   = var_q;
    rec_wr.head       = HEAD_W'(h_next);
    ring_wr.bias      = {{7{bias_q[40]}}, bias_q};
    ring_wr.dev       = d2_q;
  end

  assign ring_raddr = {sat_a, oi};
  assign ring_waddr = {sat_a, h_cur};

  cpcsd_ram #(
    .WIDTH($bits(slot_rec_t)),
    .DEPTH(SATELLITES),
    .AW   (SW)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(sat_a),
    .wdata_i(rec_wr),
    .re_i   (slot_re),
    .raddr_i(sat_a),
    .rdata_o(slot_rdata)
  );

  cpcsd_ram #(
    .WIDTH($bits(ring_rec_t)),
    .DEPTH(2 ** RW),
    .AW   (RW)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(ring_wr),
    .re_i   (ring_re),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

`ifndef ASSERT_OFF
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input beat taken while an item is in flight");

  a_ring_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_we && ring_re))
    else $error("ring read and write in the same cycle");

  a_div_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_cnt_q != 6'd0))
    else $error("divider running with no steps left");

  a_write_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we |=> (state_q == ST_OUT) && valid_q[sat_a])
    else $error("slot write not followed by result");
`endif

endmodule
`default_nettype wire
